@@ src/pce_pkg.sv @@
// Shared types, constants and byte helpers for the percent escape codec.
package pce_pkg;

    typedef logic [7:0] t_byte;

    localparam t_byte PERCENT = 8'h25;
    localparam t_byte SPACE   = 8'h20;
    localparam t_byte CHAR_0  = 8'h30;
    localparam t_byte CHAR_A  = 8'h41;
    localparam t_byte CASE_MASK = 8'hDF;
    localparam t_byte TEN     = 8'd10;

    // Escape tracking in decode mode
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } t_phase;

    typedef struct packed {
        t_byte in_byte;
        logic  end_of_run;
    } t_item;

    // Zero to three result bytes caused by one input item, bytes[0] goes out first
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            last;
        logic            cut;
    } t_group;

    function automatic logic is_alnum(input t_byte b);
        is_alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                   (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic needs_escape(input t_byte b);
        needs_escape = !is_alnum(b) && (b != SPACE) && (b != 8'h00) && !b[7];
    endfunction

    function automatic t_byte hex_upper(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_upper = CHAR_0 + {4'h0, nib};
        end else begin
            hex_upper = CHAR_A + {4'h0, nib} - TEN;
        end
    endfunction

    // No validation: wraps mod 256 for any byte
    function automatic t_byte digit_value(input t_byte ch);
        if (ch >= CHAR_A) begin
            digit_value = (ch & CASE_MASK) - CHAR_A + TEN;
        end else begin
            digit_value = ch - CHAR_0;
        end
    endfunction

endpackage

@@ src/pce_if.sv @@
// Handshake channel interfaces: input bytes, result bytes, mode register writes.
interface pce_in_if;
    logic          valid;
    logic          ready;
    pce_pkg::t_byte in_byte;
    logic          end_of_run;
    modport source(output valid, output in_byte, output end_of_run, input ready);
    modport sink(input valid, input in_byte, input end_of_run, output ready);
endinterface

interface pce_out_if;
    logic          valid;
    logic          ready;
    pce_pkg::t_byte out_byte;
    logic          out_last;
    logic          cut_escape;
    modport source(output valid, output out_byte, output out_last, output cut_escape,
                   input ready);
    modport sink(input valid, input out_byte, input out_last, input cut_escape,
                 output ready);
endinterface

interface pce_cfg_if;
    logic valid;
    logic ready;
    logic decode_mode;
    modport source(output valid, output decode_mode, input ready);
    modport sink(input valid, input decode_mode, output ready);
endinterface

@@ src/percent_escape_codec_unit.sv @@
// Top level of the percent escape codec: input register, codec logic, result serializer.
// Byte-stream URL percent codec. With decode_mode 0 each byte in 0x01..0x7F that is not a
// letter, digit or space becomes '%' and two upper-case hex digits; other bytes pass.
// With decode_mode 1 a '%' and the two following bytes collapse into one byte (digits
// not checked); a run ending inside an escape gives one zero byte with cut_escape and
// out_last set. Accepted bytes sit in an input register, are converted combinationally
// and the results go out of a result register one byte per cycle while the receiver
// is ready. The input register passes an item on once the result register is empty or
// sends its final byte. The register write is always ready and clears any pending
// escape. The user must make it only while the block is idle; no logic enforces it.
module percent_escape_codec_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pce_in_if.sink     i_in,
    pce_out_if.source  o_out,
    pce_cfg_if.sink    i_cfg
);

    logic            r_item_valid;
    pce_pkg::t_item  r_item;
    pce_pkg::t_group group;
    logic            grp_free;
    logic            item_take;
    logic            cfg_write;

    assign item_take  = r_item_valid && grp_free;
    assign i_in.ready = !r_item_valid || item_take;
    assign i_cfg.ready = 1'b1;
    assign cfg_write  = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_item_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.in_byte    <= i_in.in_byte;
            r_item.end_of_run <= i_in.end_of_run;
        end
    end

    pce_codec_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (r_item),
        .i_take      (item_take),
        .i_cfg_write (cfg_write),
        .i_cfg_mode  (i_cfg.decode_mode),
        .o_group     (group)
    );

    // items that produce nothing (escape lead-in, first digit) are simply consumed
    pce_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (item_take && (group.cnt != 2'd0)),
        .i_group (group),
        .o_free  (grp_free),
        .o_out   (o_out)
    );

endmodule

@@ src/pce_codec_core.sv @@
// Mode register, escape state and the per-item encode/decode logic.
module pce_codec_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pce_pkg::t_item  i_item,
    input  logic            i_take,
    input  logic            i_cfg_write,
    input  logic            i_cfg_mode,
    output pce_pkg::t_group o_group
);

    logic             r_mode;
    pce_pkg::t_phase  r_phase, n_phase;
    logic [3:0]       r_high, n_high;
    pce_pkg::t_byte   dval;

    assign dval = pce_pkg::digit_value(i_item.in_byte);

    always_comb begin
        o_group = '0;
        n_phase = r_phase;
        n_high  = r_high;
        if (!r_mode) begin
            if (pce_pkg::needs_escape(i_item.in_byte)) begin
                o_group.cnt      = 2'd3;
                o_group.bytes[0] = pce_pkg::PERCENT;
                o_group.bytes[1] = pce_pkg::hex_upper(i_item.in_byte[7:4]);
                o_group.bytes[2] = pce_pkg::hex_upper(i_item.in_byte[3:0]);
            end else begin
                o_group.cnt      = 2'd1;
                o_group.bytes[0] = i_item.in_byte;
            end
            o_group.last = i_item.end_of_run;
        end else begin
            unique case (r_phase)
                pce_pkg::PH_HIGH: begin
                    n_phase = pce_pkg::PH_IDLE;
                    n_high  = 4'h0;
                    if (i_item.end_of_run) begin
                        // run cut inside the escape
                        o_group.cnt  = 2'd1;
                        o_group.last = 1'b1;
                        o_group.cut  = 1'b1;
                    end else begin
                        n_phase = pce_pkg::PH_LOW;
                        n_high  = dval[3:0];
                    end
                end
                pce_pkg::PH_LOW: begin
                    n_phase          = pce_pkg::PH_IDLE;
                    n_high           = 4'h0;
                    o_group.cnt      = 2'd1;
                    o_group.bytes[0] = {r_high, 4'h0} + dval;
                    o_group.last     = i_item.end_of_run;
                end
                default: begin
                    n_phase = pce_pkg::PH_IDLE;
                    if (i_item.in_byte == pce_pkg::PERCENT) begin
                        if (i_item.end_of_run) begin
                            o_group.cnt  = 2'd1;
                            o_group.last = 1'b1;
                            o_group.cut  = 1'b1;
                        end else begin
                            n_phase = pce_pkg::PH_HIGH;
                        end
                    end else begin
                        o_group.cnt      = 2'd1;
                        o_group.bytes[0] = i_item.in_byte;
                        o_group.last     = i_item.end_of_run;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_phase <= pce_pkg::PH_IDLE;
            r_high  <= 4'h0;
        end else if (i_cfg_write) begin
            r_mode  <= i_cfg_mode;
            r_phase <= pce_pkg::PH_IDLE;
            r_high  <= 4'h0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_high  <= n_high;
        end
    end

endmodule

@@ src/pce_serializer.sv @@
// Result register: holds one group of result bytes, sends one per ready cycle.
module pce_serializer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  pce_pkg::t_group    i_group,
    output logic               o_free,
    pce_out_if.source          o_out
);

    logic            r_valid;
    pce_pkg::t_group r_grp;
    logic [1:0]      r_idx;
    logic            final_byte;
    logic            xfer;

    assign final_byte = (r_idx == r_grp.cnt - 2'd1);
    assign xfer       = o_out.valid && o_out.ready;
    assign o_free     = !r_valid || (xfer && final_byte);

    assign o_out.valid      = r_valid;
    assign o_out.out_last   = r_grp.last && final_byte;
    assign o_out.cut_escape = r_grp.cut;

    always_comb begin
        case (r_idx)
            2'd1:    o_out.out_byte = r_grp.bytes[1];
            2'd2:    o_out.out_byte = r_grp.bytes[2];
            default: o_out.out_byte = r_grp.bytes[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (xfer) begin
            if (final_byte) begin
                r_valid <= 1'b0;
                r_idx   <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_group;
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_grp.cnt != 2'd0) && (r_idx < r_grp.cnt))
        else $error("result index outside its group");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("group loaded over unsent bytes");

    a_cut_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_grp.cut) |-> (o_out.out_byte == 8'h00) && o_out.out_last)
        else $error("cut result not a zero last byte");

    a_group_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && !final_byte) |=> r_valid && (r_idx == $past(r_idx) + 2'd1))
        else $error("group dropped before its final byte");
`endif

endmodule
